@@ src/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants for the profiling stopwatch with rounded average.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int TICK_W  = 32;
    localparam int COUNT_W = 16;
    localparam int OP_W    = 2;

    // event operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_SAMPLE = 2'd3
    } t_psa_op;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // take the input word and update the stopwatch state
        logic div_step;  // run one restoring divide step
        logic load_out;  // move the finished result into the output register
    } t_psa_cmd;

endpackage

@@ src/psa_in_if.sv @@
// ----------------------------------------------------------------------------
// psa_in_if
// Event channel: operation code and tick timestamp, valid/ready handshake.
// ----------------------------------------------------------------------------
interface psa_in_if;

    logic                                valid;
    logic                                ready;
    logic [psa_pkg::OP_W-1:0]            op;
    logic [psa_pkg::TICK_W-1:0]          now_ticks;

    modport source (output valid, output op, output now_ticks, input ready);
    modport sink   (input valid, input op, input now_ticks, output ready);

endinterface

@@ src/psa_out_if.sv @@
// ----------------------------------------------------------------------------
// psa_out_if
// Result channel: stopwatch readings, valid/ready handshake.
// ----------------------------------------------------------------------------
interface psa_out_if;

    logic                                valid;
    logic                                ready;
    logic [psa_pkg::TICK_W-1:0]          current_ticks;
    logic [psa_pkg::TICK_W-1:0]          average_ticks;
    logic [psa_pkg::TICK_W-1:0]          total_ticks;
    logic [psa_pkg::COUNT_W-1:0]         run_count;
    logic                                running;

    modport source (output valid, output current_ticks, output average_ticks,
                    output total_ticks, output run_count, output running,
                    input ready);
    modport sink   (input valid, input current_ticks, input average_ticks,
                    input total_ticks, input run_count, input running,
                    output ready);

endinterface

@@ src/psa_datapath.sv @@
// ----------------------------------------------------------------------------
// psa_datapath
// Stopwatch state, event update, radix-2 restoring divider and result register.
// ----------------------------------------------------------------------------
module psa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psa_pkg::t_psa_cmd             i_cmd,
    input  logic [psa_pkg::OP_W-1:0]      i_op,
    input  logic [psa_pkg::TICK_W-1:0]    i_now_ticks,
    output logic [psa_pkg::TICK_W-1:0]    o_current_ticks,
    output logic [psa_pkg::TICK_W-1:0]    o_average_ticks,
    output logic [psa_pkg::TICK_W-1:0]    o_total_ticks,
    output logic [psa_pkg::COUNT_W-1:0]   o_run_count,
    output logic                          o_running
);
    import psa_pkg::*;

    // stopwatch state
    logic [TICK_W-1:0]  r_stamp, n_stamp;
    logic [TICK_W-1:0]  r_sum, n_sum;
    logic [COUNT_W-1:0] r_runs, n_runs;
    logic [TICK_W-1:0]  r_last, n_last;
    logic               r_active, n_active;
    logic [TICK_W-1:0]  n_cur;

    // divider and snapshot
    logic [TICK_W-1:0]  r_cur;
    logic [TICK_W-1:0]  r_quo;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_div;
    logic [COUNT_W:0]   s_shift;
    logic               s_ge;
    logic [COUNT_W-1:0] n_rem;

    // result register
    logic [TICK_W-1:0]  r_o_cur;
    logic [TICK_W-1:0]  r_o_avg;
    logic [TICK_W-1:0]  r_o_sum;
    logic [COUNT_W-1:0] r_o_runs;
    logic               r_o_active;

    // apply the event operation
    always_comb begin
        n_stamp  = r_stamp;
        n_sum    = r_sum;
        n_runs   = r_runs;
        n_last   = r_last;
        n_active = r_active;
        unique case (t_psa_op'(i_op))
            OP_CLEAR: begin
                n_stamp  = '0;
                n_sum    = '0;
                n_runs   = '0;
                n_active = 1'b0;
            end
            OP_START: begin
                if (!r_active) begin
                    n_stamp  = i_now_ticks;
                    n_active = 1'b1;
                end
            end
            OP_STOP: begin
                if (r_active) begin
                    n_last   = i_now_ticks - r_stamp;
                    n_sum    = r_sum + (i_now_ticks - r_stamp);
                    n_runs   = r_runs + COUNT_W'(1);
                    n_active = 1'b0;
                end
            end
            OP_SAMPLE: begin
            end
            default: begin
            end
        endcase
        n_cur = n_active ? (i_now_ticks - n_stamp) : n_last;
    end

    // one divide step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        s_shift = {r_rem, r_quo[TICK_W-1]};
        s_ge    = (s_shift >= {1'b0, r_div});
        n_rem   = s_ge ? COUNT_W'(s_shift - {1'b0, r_div}) : s_shift[COUNT_W-1:0];
    end

    // hold state, run the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp  <= '0;
            r_sum    <= '0;
            r_runs   <= '0;
            r_last   <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.accept) begin
            r_stamp  <= n_stamp;
            r_sum    <= n_sum;
            r_runs   <= n_runs;
            r_last   <= n_last;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur <= n_cur;
            r_rem <= '0;
            r_div <= n_runs;
            // rounding bias wraps modulo 2^32 before the division
            r_quo <= n_sum + TICK_W'(n_runs >> 1);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[TICK_W-2:0], s_ge};
        end
    end

    // capture the finished result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_cur    <= r_cur;
            r_o_avg    <= (r_div == '0) ? '0 : r_quo;
            r_o_sum    <= r_sum;
            r_o_runs   <= r_runs;
            r_o_active <= r_active;
        end
    end

    assign o_current_ticks = r_o_cur;
    assign o_average_ticks = r_o_avg;
    assign o_total_ticks   = r_o_sum;
    assign o_run_count     = r_o_runs;
    assign o_running       = r_o_active;

endmodule

@@ src/psa_ctrl.sv @@
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer: takes one event word, steps the divider, hands off the result.
// ----------------------------------------------------------------------------
module psa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output psa_pkg::t_psa_cmd o_cmd
);
    import psa_pkg::*;

    localparam int STEP_W = $clog2(TICK_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              s_out_free;

    assign s_out_free = !r_out_valid || i_out_ready;

    // commands from the current state; load only once the last step has landed
    always_comb begin
        o_cmd.accept   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.load_out = (r_state == ST_HOLD) && s_out_free;
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DIV;
                    n_step  = '0;
                end
            end
            ST_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == ST_DIV) && (r_step == '0))
        else $error("accepted word did not start the divider");

    a_div_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_step != LAST_STEP)) |=>
            (r_state == ST_DIV) && (r_step == $past(r_step) + STEP_W'(1)))
        else $error("divider step count did not advance");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.load_out))
        else $error("result valid raised without a load");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.load_out)
        else $error("pending result overwritten");
`endif

endmodule

@@ src/profile_stopwatch_average_top.sv @@
// ----------------------------------------------------------------------------
// profile_stopwatch_average_top
// Start/stop profiling stopwatch with a rounded running average of runs.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one event word: op (clear, start, stop, sample) and the
//   current value of a free-running 32-bit tick counter. Every event word
//   yields exactly one result word on o_out: current elapsed ticks (or the
//   last duration when idle), rounded average, total, run count, running.
//   After an event is accepted, the radix-2 restoring divider runs its 32
//   steps, then one load moves the result to o_out once the output is free.
//   i_in.ready is high only while the sequencer is idle, so no new event is
//   taken until the previous result has moved to the output register.
//   A finished result waits in the output register while the next event is
//   taken; if the receiver stalls, the following result waits inside the
//   block until the output register empties, and no new event is accepted.
//   Reset (synchronous, active low) clears the stamp, total, count, last
//   duration and running flag and drops any pending result.
// ----------------------------------------------------------------------------
module profile_stopwatch_average_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psa_in_if.sink    i_in,
    psa_out_if.source o_out
);
    import psa_pkg::*;

    t_psa_cmd s_cmd;

    psa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (s_cmd)
    );

    psa_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .i_op            (i_in.op),
        .i_now_ticks     (i_in.now_ticks),
        .o_current_ticks (o_out.current_ticks),
        .o_average_ticks (o_out.average_ticks),
        .o_total_ticks   (o_out.total_ticks),
        .o_run_count     (o_out.run_count),
        .o_running       (o_out.running)
    );

endmodule
